>>> rtl/core/assert_macros.svh
// assertion macros used by the rgb pixel format writer datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rgbpf_pkg.sv
// types, constants and helpers of the rgb pixel format writer
package rgbpf_pkg;

    // field widths
    localparam int unsigned COORD_WIDTH  = 12;
    localparam int unsigned COLOR_WIDTH  = 24;
    localparam int unsigned OFFSET_WIDTH = 28;
    localparam int unsigned WORD_WIDTH   = 32;
    localparam int unsigned BPP_WIDTH    = 3;
    localparam int unsigned PITCH_WIDTH  = 16;
    localparam int unsigned SIZE_WIDTH   = 4;
    localparam int unsigned SHIFT_WIDTH  = 5;
    localparam int unsigned CHAN_WIDTH   = 8;
    localparam int unsigned NUM_CHAN     = 3;

    // configuration port
    localparam int unsigned ADDR_WIDTH = 5;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned IDX_LSB    = 2;
    localparam int unsigned IDX_WIDTH  = 3;

    // channel scaling: chan * (2^size - 1) fits 23 bits, quotient by 255 fits 15 bits
    localparam int unsigned PROD_WIDTH   = CHAN_WIDTH + (1 << SIZE_WIDTH) - 1;
    localparam int unsigned QUOT_WIDTH   = (1 << SIZE_WIDTH) - 1;
    localparam int unsigned RECIP_WIDTH  = 24;
    localparam int unsigned RECIP_SHIFT  = 31;
    localparam int unsigned RPROD_WIDTH  = PROD_WIDTH + RECIP_WIDTH;
    localparam logic [RECIP_WIDTH-1:0] RECIP_255 = 24'h808080;
    localparam logic [CHAN_WIDTH-1:0]  CHAN_MAX  = 8'hFF;

    // bytes per pixel limits
    localparam logic [BPP_WIDTH-1:0] BPP_MIN = 3'd2;
    localparam logic [BPP_WIDTH-1:0] BPP_MAX = 3'd4;

    // register reset values
    localparam logic [PITCH_WIDTH-1:0] PITCH_RESET       = 16'd16384;
    localparam logic [BPP_WIDTH-1:0]   BPP_RESET         = 3'd4;
    localparam logic [SIZE_WIDTH-1:0]  SIZE_RESET        = 4'd8;
    localparam logic [SHIFT_WIDTH-1:0] RED_SHIFT_RESET   = 5'd16;
    localparam logic [SHIFT_WIDTH-1:0] GREEN_SHIFT_RESET = 5'd8;
    localparam logic [SHIFT_WIDTH-1:0] BLUE_SHIFT_RESET  = 5'd0;

    // channel order in the colour and the register arrays
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    // register indexes
    typedef enum logic [IDX_WIDTH-1:0] {
        REG_PITCH       = 3'd0,
        REG_BPP         = 3'd1,
        REG_RED_SIZE    = 3'd2,
        REG_RED_SHIFT   = 3'd3,
        REG_GREEN_SIZE  = 3'd4,
        REG_GREEN_SHIFT = 3'd5,
        REG_BLUE_SIZE   = 3'd6,
        REG_BLUE_SHIFT  = 3'd7
    } t_reg_idx;

    // request payloads
    typedef struct packed {
        logic [COORD_WIDTH-1:0] pixel_x;
        logic [COORD_WIDTH-1:0] pixel_y;
        logic [COLOR_WIDTH-1:0] rgb_color;
    } t_pix_in;

    typedef struct packed {
        logic [OFFSET_WIDTH-1:0] byte_offset;
        logic [WORD_WIDTH-1:0]   pixel_word;
        logic [BPP_WIDTH-1:0]    store_bytes;
    } t_pix_out;

    // configuration seen by the datapath
    typedef struct packed {
        logic [PITCH_WIDTH-1:0]                 pitch;
        logic [BPP_WIDTH-1:0]                   bpp;
        logic [NUM_CHAN-1:0][SIZE_WIDTH-1:0]    size;
        logic [NUM_CHAN-1:0][SHIFT_WIDTH-1:0]   shift;
    } t_cfg;

    // clamp bytes per pixel into 2..4
    function automatic logic [BPP_WIDTH-1:0] clamp_bpp(input logic [BPP_WIDTH-1:0] bpp);
        logic [BPP_WIDTH-1:0] res;
        if (bpp < BPP_MIN) begin
            res = BPP_MIN;
        end else if (bpp > BPP_MAX) begin
            res = BPP_MAX;
        end else begin
            res = bpp;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/rgbpf_cfg.sv
// configuration register file with apb-style access
module rgbpf_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rgbpf_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [rgbpf_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic [rgbpf_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                               pready,
    output rgbpf_pkg::t_cfg                    o_cfg
);

    rgbpf_pkg::t_cfg      r_cfg;
    rgbpf_pkg::t_reg_idx  w_idx;
    logic                 w_wr;

    assign w_idx  = rgbpf_pkg::t_reg_idx'(paddr[rgbpf_pkg::IDX_LSB +: rgbpf_pkg::IDX_WIDTH]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pitch                     <= rgbpf_pkg::PITCH_RESET;
            r_cfg.bpp                       <= rgbpf_pkg::BPP_RESET;
            r_cfg.size[rgbpf_pkg::CH_RED]   <= rgbpf_pkg::SIZE_RESET;
            r_cfg.size[rgbpf_pkg::CH_GREEN] <= rgbpf_pkg::SIZE_RESET;
            r_cfg.size[rgbpf_pkg::CH_BLUE]  <= rgbpf_pkg::SIZE_RESET;
            r_cfg.shift[rgbpf_pkg::CH_RED]   <= rgbpf_pkg::RED_SHIFT_RESET;
            r_cfg.shift[rgbpf_pkg::CH_GREEN] <= rgbpf_pkg::GREEN_SHIFT_RESET;
            r_cfg.shift[rgbpf_pkg::CH_BLUE]  <= rgbpf_pkg::BLUE_SHIFT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                rgbpf_pkg::REG_PITCH: begin
                    r_cfg.pitch <= pwdata[rgbpf_pkg::PITCH_WIDTH-1:0];
                end
                rgbpf_pkg::REG_BPP: begin
                    r_cfg.bpp <= pwdata[rgbpf_pkg::BPP_WIDTH-1:0];
                end
                rgbpf_pkg::REG_RED_SIZE: begin
                    r_cfg.size[rgbpf_pkg::CH_RED] <= pwdata[rgbpf_pkg::SIZE_WIDTH-1:0];
                end
                rgbpf_pkg::REG_RED_SHIFT: begin
                    r_cfg.shift[rgbpf_pkg::CH_RED] <= pwdata[rgbpf_pkg::SHIFT_WIDTH-1:0];
                end
                rgbpf_pkg::REG_GREEN_SIZE: begin
                    r_cfg.size[rgbpf_pkg::CH_GREEN] <= pwdata[rgbpf_pkg::SIZE_WIDTH-1:0];
                end
                rgbpf_pkg::REG_GREEN_SHIFT: begin
                    r_cfg.shift[rgbpf_pkg::CH_GREEN] <= pwdata[rgbpf_pkg::SHIFT_WIDTH-1:0];
                end
                rgbpf_pkg::REG_BLUE_SIZE: begin
                    r_cfg.size[rgbpf_pkg::CH_BLUE] <= pwdata[rgbpf_pkg::SIZE_WIDTH-1:0];
                end
                rgbpf_pkg::REG_BLUE_SHIFT: begin
                    r_cfg.shift[rgbpf_pkg::CH_BLUE] <= pwdata[rgbpf_pkg::SHIFT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (w_idx)
            rgbpf_pkg::REG_PITCH:
                prdata = rgbpf_pkg::DATA_WIDTH'(r_cfg.pitch);
            rgbpf_pkg::REG_BPP:
                prdata = rgbpf_pkg::DATA_WIDTH'(r_cfg.bpp);
            rgbpf_pkg::REG_RED_SIZE:
                prdata = rgbpf_pkg::DATA_WIDTH'(r_cfg.size[rgbpf_pkg::CH_RED]);
            rgbpf_pkg::REG_RED_SHIFT:
                prdata = rgbpf_pkg::DATA_WIDTH'(r_cfg.shift[rgbpf_pkg::CH_RED]);
            rgbpf_pkg::REG_GREEN_SIZE:
                prdata = rgbpf_pkg::DATA_WIDTH'(r_cfg.size[rgbpf_pkg::CH_GREEN]);
            rgbpf_pkg::REG_GREEN_SHIFT:
                prdata = rgbpf_pkg::DATA_WIDTH'(r_cfg.shift[rgbpf_pkg::CH_GREEN]);
            rgbpf_pkg::REG_BLUE_SIZE:
                prdata = rgbpf_pkg::DATA_WIDTH'(r_cfg.size[rgbpf_pkg::CH_BLUE]);
            rgbpf_pkg::REG_BLUE_SHIFT:
                prdata = rgbpf_pkg::DATA_WIDTH'(r_cfg.shift[rgbpf_pkg::CH_BLUE]);
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/rgbpf_pipe.sv
// three-stage pixel datapath: scale products, reciprocal divide, pack and output
`include "assert_macros.svh"

module rgbpf_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rgbpf_pkg::t_pix_in   i_in,
    input  rgbpf_pkg::t_cfg      i_cfg,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rgbpf_pkg::t_pix_out  o_out
);

    localparam int unsigned YP_WIDTH  = rgbpf_pkg::COORD_WIDTH + rgbpf_pkg::PITCH_WIDTH;
    localparam int unsigned XB_WIDTH  = rgbpf_pkg::COORD_WIDTH + rgbpf_pkg::BPP_WIDTH;
    localparam int unsigned SUM_WIDTH = YP_WIDTH + 1;

    // stage readiness
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;

    // stage 1 registers
    logic                                                    r_s1_valid;
    logic [rgbpf_pkg::NUM_CHAN-1:0][rgbpf_pkg::PROD_WIDTH-1:0] r_s1_prod;
    logic [YP_WIDTH-1:0]                                     r_s1_yp;
    logic [XB_WIDTH-1:0]                                     r_s1_xb;
    logic [rgbpf_pkg::BPP_WIDTH-1:0]                         r_s1_bpp;

    // stage 2 registers
    logic                                                    r_s2_valid;
    logic [rgbpf_pkg::NUM_CHAN-1:0][rgbpf_pkg::PROD_WIDTH-1:0] r_s2_prod;
    logic [rgbpf_pkg::NUM_CHAN-1:0][rgbpf_pkg::QUOT_WIDTH-1:0] r_s2_quot;
    logic [rgbpf_pkg::OFFSET_WIDTH-1:0]                      r_s2_off;
    logic [rgbpf_pkg::BPP_WIDTH-1:0]                         r_s2_bpp;

    // output registers
    logic                 r_out_valid;
    rgbpf_pkg::t_pix_out  r_out;

    // next values
    logic [rgbpf_pkg::NUM_CHAN-1:0][rgbpf_pkg::PROD_WIDTH-1:0] n_s1_prod;
    logic [YP_WIDTH-1:0]                                     n_s1_yp;
    logic [XB_WIDTH-1:0]                                     n_s1_xb;
    logic [rgbpf_pkg::BPP_WIDTH-1:0]                         n_s1_bpp;
    logic [rgbpf_pkg::NUM_CHAN-1:0][rgbpf_pkg::QUOT_WIDTH-1:0] n_s2_quot;
    logic [rgbpf_pkg::OFFSET_WIDTH-1:0]                      n_s2_off;
    logic [rgbpf_pkg::WORD_WIDTH-1:0]                        n_word;

    // intermediate terms
    logic [rgbpf_pkg::NUM_CHAN-1:0][rgbpf_pkg::RPROD_WIDTH-1:0] w_rprod;
    logic [rgbpf_pkg::NUM_CHAN-1:0][rgbpf_pkg::PROD_WIDTH-1:0]  w_mul255;
    logic [rgbpf_pkg::NUM_CHAN-1:0][rgbpf_pkg::PROD_WIDTH-1:0]  w_rem;
    logic [rgbpf_pkg::NUM_CHAN-1:0][rgbpf_pkg::QUOT_WIDTH-1:0]  w_quot;
    logic [SUM_WIDTH-1:0]                                      w_off_sum;
    logic                                                      w_quot_ok;

    // ready chain: a stage takes data when empty or when it moves on
    assign w_rdy3  = !r_out_valid || !i_stall;
    assign w_rdy2  = !r_s2_valid || w_rdy3;
    assign w_rdy1  = !r_s1_valid || w_rdy2;
    assign o_stall = !w_rdy1;

    // stage 1: chan * (2^size - 1) as shift and subtract, offset products, bpp clamp
    always_comb begin
        logic [rgbpf_pkg::PROD_WIDTH-1:0] chan;
        for (int c = 0; c < rgbpf_pkg::NUM_CHAN; c++) begin
            chan = rgbpf_pkg::PROD_WIDTH'(i_in.rgb_color[rgbpf_pkg::CHAN_WIDTH *
                    (rgbpf_pkg::NUM_CHAN - 1 - c) +: rgbpf_pkg::CHAN_WIDTH]);
            n_s1_prod[c] = (chan << i_cfg.size[c]) - chan;
        end
        n_s1_bpp = rgbpf_pkg::clamp_bpp(i_cfg.bpp);
        n_s1_yp  = YP_WIDTH'(i_in.pixel_y) * YP_WIDTH'(i_cfg.pitch);
        n_s1_xb  = XB_WIDTH'(i_in.pixel_x) * XB_WIDTH'(n_s1_bpp);
    end

    // stage 2: quotient estimate by reciprocal of 255, offset sum
    always_comb begin
        for (int c = 0; c < rgbpf_pkg::NUM_CHAN; c++) begin
            w_rprod[c]   = rgbpf_pkg::RPROD_WIDTH'(r_s1_prod[c]) *
                           rgbpf_pkg::RPROD_WIDTH'(rgbpf_pkg::RECIP_255);
            n_s2_quot[c] = w_rprod[c][rgbpf_pkg::RECIP_SHIFT +: rgbpf_pkg::QUOT_WIDTH];
        end
        w_off_sum = SUM_WIDTH'(r_s1_yp) + SUM_WIDTH'(r_s1_xb);
        n_s2_off  = rgbpf_pkg::OFFSET_WIDTH'(w_off_sum);
    end

    // stage 3: one-step quotient correction, place fields and merge
    always_comb begin
        n_word    = '0;
        w_quot_ok = 1'b1;
        for (int c = 0; c < rgbpf_pkg::NUM_CHAN; c++) begin
            w_mul255[c] = (rgbpf_pkg::PROD_WIDTH'(r_s2_quot[c]) << rgbpf_pkg::CHAN_WIDTH) -
                          rgbpf_pkg::PROD_WIDTH'(r_s2_quot[c]);
            w_rem[c]    = r_s2_prod[c] - w_mul255[c];
            if (w_rem[c] >= rgbpf_pkg::PROD_WIDTH'(rgbpf_pkg::CHAN_MAX)) begin
                w_quot[c] = r_s2_quot[c] + 1'b1;
            end else begin
                w_quot[c] = r_s2_quot[c];
            end
            n_word    = n_word | (rgbpf_pkg::WORD_WIDTH'(w_quot[c]) << i_cfg.shift[c]);
            w_quot_ok = w_quot_ok & (w_mul255[c] <= r_s2_prod[c]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= i_valid;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_rdy3) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1_prod <= n_s1_prod;
            r_s1_yp   <= n_s1_yp;
            r_s1_xb   <= n_s1_xb;
            r_s1_bpp  <= n_s1_bpp;
        end
        if (w_rdy2 && r_s1_valid) begin
            r_s2_prod <= r_s1_prod;
            r_s2_quot <= n_s2_quot;
            r_s2_off  <= n_s2_off;
            r_s2_bpp  <= r_s1_bpp;
        end
        if (w_rdy3 && r_s2_valid) begin
            r_out.byte_offset <= r_s2_off;
            r_out.pixel_word  <= n_word;
            r_out.store_bytes <= r_s2_bpp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // checks
    `ASSERT_IMPL(a_store_bytes_range, i_clk, i_rst_n, r_out_valid,
        (r_out.store_bytes >= rgbpf_pkg::BPP_MIN) && (r_out.store_bytes <= rgbpf_pkg::BPP_MAX),
        "store_bytes outside 2..4")
    `ASSERT_IMPL(a_quot_not_over, i_clk, i_rst_n, r_s2_valid, w_quot_ok,
        "reciprocal quotient estimate above true quotient")
    `ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !w_rdy2, r_s1_valid,
        "stage 1 request lost while blocked")
    `ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, i_valid && !o_stall, r_s1_valid,
        "accepted request did not enter stage 1")

endmodule

>>> rtl/core/rgb_pixel_format_writer.sv
// rgb pixel format writer top level: colour scaling, packing and framebuffer offset
// an accepted request passes through the stage 1 and stage 2 registers to the output register
// throughput: one pixel per cycle while i_stall is low; each of the three stages moves on when the next one has room
// the per-stage ready chain fills bubbles, so a new request enters while a result waits
// reset: synchronous active-low clears the valid bits and restores the register defaults
module rgb_pixel_format_writer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rgbpf_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [rgbpf_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic [rgbpf_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  rgbpf_pkg::t_pix_in                 i_in_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output rgbpf_pkg::t_pix_out                o_out_data
);

    rgbpf_pkg::t_cfg w_cfg;

    // configuration registers
    rgbpf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // pixel datapath
    rgbpf_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in_data),
        .i_cfg   (w_cfg),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out_data)
    );

endmodule

>>> tb/rgb_pixel_format_writer_tb.sv
// self-checking testbench for the rgb pixel format writer
module rgb_pixel_format_writer_tb;
    import rgbpf_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned MAX_WAIT     = 19;
    localparam int unsigned PIPE_DEPTH   = 3;
    localparam int unsigned PHASES       = 10;
    localparam int unsigned PHASE_ITEMS  = 200;
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_stall;
    t_pix_in               i_in_data;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_pix_out              o_out_data;

    // framebuffer format as last written through the register port
    logic [PITCH_WIDTH-1:0] fmt_pitch;
    logic [BPP_WIDTH-1:0]   fmt_bpp;
    logic [SIZE_WIDTH-1:0]  fmt_size  [NUM_CHAN];
    logic [SHIFT_WIDTH-1:0] fmt_shift [NUM_CHAN];

    t_pix_out    expected_stores [$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned stall_left     = 0;
    bit          src_idle       = 1'b1;
    bit          snk_idle       = 1'b1;

    rgb_pixel_format_writer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_data (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // expected framebuffer store for one pixel under the current format
    function automatic t_pix_out predict_pixel_store(input t_pix_in px);
        t_pix_out              res;
        logic [63:0]           word;
        logic [63:0]           offset;
        logic [BPP_WIDTH-1:0]  bpp;
        logic [CHAN_WIDTH-1:0] chan;
        logic [31:0]           full;
        logic [31:0]           scaled;
        word = '0;
        // out-of-range depths saturate into two..four bytes
        if (fmt_bpp < BPP_MIN) begin
            bpp = BPP_MIN;
        end else if (fmt_bpp > BPP_MAX) begin
            bpp = BPP_MAX;
        end else begin
            bpp = fmt_bpp;
        end
        // scale each channel to its field width, place it, drop bits above 31
        for (int c = 0; c < NUM_CHAN; c++) begin
            chan   = px.rgb_color[COLOR_WIDTH-1-CHAN_WIDTH*c -: CHAN_WIDTH];
            full   = (32'd1 << fmt_size[c]) - 32'd1;
            scaled = (32'(chan) * full) / 32'd255;
            word   = word | (64'(scaled) << fmt_shift[c]);
        end
        offset = 64'(px.pixel_y) * 64'(fmt_pitch) + 64'(px.pixel_x) * 64'(bpp);
        res.byte_offset = offset[OFFSET_WIDTH-1:0];
        res.pixel_word  = word[WORD_WIDTH-1:0];
        res.store_bytes = bpp;
        return res;
    endfunction

    function automatic t_pix_in make_pixel(input int unsigned x, input int unsigned y,
                                           input logic [COLOR_WIDTH-1:0] colour);
        t_pix_in px;
        px.pixel_x   = COORD_WIDTH'(x);
        px.pixel_y   = COORD_WIDTH'(y);
        px.rgb_color = colour;
        return px;
    endfunction

    // coordinate biased towards the edges of the range
    function automatic logic [COORD_WIDTH-1:0] pick_coord();
        logic [COORD_WIDTH-1:0] v;
        if ($urandom_range(0, 15) == 0) begin
            v = $urandom_range(0, 1) ? COORD_MAX : '0;
        end else begin
            v = COORD_WIDTH'($urandom());
        end
        return v;
    endfunction

    function automatic t_pix_in random_pixel();
        t_pix_in px;
        px.pixel_x = pick_coord();
        px.pixel_y = pick_coord();
        // channels often black or saturated
        for (int c = 0; c < NUM_CHAN; c++) begin
            case ($urandom_range(0, 7))
                0:       px.rgb_color[COLOR_WIDTH-1-CHAN_WIDTH*c -: CHAN_WIDTH] = '0;
                1:       px.rgb_color[COLOR_WIDTH-1-CHAN_WIDTH*c -: CHAN_WIDTH] = CHAN_MAX;
                default: px.rgb_color[COLOR_WIDTH-1-CHAN_WIDTH*c -: CHAN_WIDTH] =
                             CHAN_WIDTH'($urandom());
            endcase
        end
        return px;
    endfunction

    // one register write: setup cycle, then access cycle until pready
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'(idx) << IDX_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PITCH:       fmt_pitch          = value[PITCH_WIDTH-1:0];
            REG_BPP:         fmt_bpp            = value[BPP_WIDTH-1:0];
            REG_RED_SIZE:    fmt_size[CH_RED]    = value[SIZE_WIDTH-1:0];
            REG_RED_SHIFT:   fmt_shift[CH_RED]   = value[SHIFT_WIDTH-1:0];
            REG_GREEN_SIZE:  fmt_size[CH_GREEN]  = value[SIZE_WIDTH-1:0];
            REG_GREEN_SHIFT: fmt_shift[CH_GREEN] = value[SHIFT_WIDTH-1:0];
            REG_BLUE_SIZE:   fmt_size[CH_BLUE]   = value[SIZE_WIDTH-1:0];
            REG_BLUE_SHIFT:  fmt_shift[CH_BLUE]  = value[SHIFT_WIDTH-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_format(input int unsigned pitch, input int unsigned bpp,
                              input int unsigned r_size, input int unsigned r_shift,
                              input int unsigned g_size, input int unsigned g_shift,
                              input int unsigned b_size, input int unsigned b_shift);
        write_reg(REG_PITCH,       pitch);
        write_reg(REG_BPP,         bpp);
        write_reg(REG_RED_SIZE,    r_size);
        write_reg(REG_RED_SHIFT,   r_shift);
        write_reg(REG_GREEN_SIZE,  g_size);
        write_reg(REG_GREEN_SHIFT, g_shift);
        write_reg(REG_BLUE_SIZE,   b_size);
        write_reg(REG_BLUE_SHIFT,  b_shift);
    endtask

    // present one request, after a random gap when the source idles, and hold it until taken
    task automatic send_pixel(input t_pix_in px);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_data <= px;
        do @(posedge i_clk); while (o_stall);
        expected_stores.push_back(predict_pixel_store(px));
    endtask

    // drop valid and let every outstanding store come out
    task automatic wait_for_stores();
        i_valid <= 1'b0;
        while (expected_stores.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    // reset format, coordinate and colour extremes, back to back
    task automatic test_reset_format();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        send_pixel(make_pixel(0, 0, 24'h000000));
        send_pixel(make_pixel(4095, 4095, 24'hFFFFFF));
        send_pixel(make_pixel(4095, 0, 24'hFF0000));
        send_pixel(make_pixel(0, 4095, 24'h00FF00));
        send_pixel(make_pixel(1, 1, 24'h0000FF));
        send_pixel(make_pixel(2048, 2047, 24'hAA55AA));
        wait_for_stores();
    endtask

    // wide and empty fields, fields past bit 31, overlaps, depth clamping, common layouts
    task automatic test_format_corners();
        src_idle = 1'b1;
        snk_idle = 1'b1;
        // fifteen-bit overlapping fields, depth below two, widest pitch
        set_format(65535, 0, 15, 0, 15, 8, 15, 16);
        send_pixel(make_pixel(4095, 4095, 24'hFFFFFF));
        send_pixel(make_pixel(3, 5, 24'h807F01));
        wait_for_stores();
        // empty fields, depth above four, zero pitch
        set_format(0, 7, 0, 16, 0, 8, 0, 0);
        send_pixel(make_pixel(4095, 4095, 24'hFFFFFF));
        wait_for_stores();
        // every field at the top bit, most of it shifted out
        set_format(1, 1, 8, 31, 8, 31, 15, 31);
        send_pixel(make_pixel(7, 9, 24'hFFFFFF));
        send_pixel(make_pixel(1, 0, 24'h010101));
        wait_for_stores();
        // 16 bpp 5:6:5
        set_format(1280, 2, 5, 11, 6, 5, 5, 0);
        send_pixel(make_pixel(639, 479, 24'hFFFFFF));
        send_pixel(make_pixel(100, 200, 24'h123456));
        wait_for_stores();
        // 24 bpp packed
        set_format(5760, 3, 8, 16, 8, 8, 8, 0);
        send_pixel(make_pixel(1919, 1079, 24'hC0FFEE));
        wait_for_stores();
        // depth just above four
        set_format(16384, 5, 8, 16, 8, 8, 8, 0);
        send_pixel(make_pixel(4095, 1, 24'h7F8081));
        wait_for_stores();
    endtask

    // random formats with random pixels under varying idle patterns
    task automatic test_random_formats();
        int unsigned pitch;
        int unsigned sz [NUM_CHAN];
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin src_idle = 1'b1; snk_idle = 1'b1; end
                1: begin src_idle = 1'b0; snk_idle = 1'b0; end
                2: begin src_idle = 1'b1; snk_idle = 1'b0; end
                default: begin src_idle = 1'b0; snk_idle = 1'b1; end
            endcase
            if (phase == 0) begin
                set_format(65535, 7, 15, 31, 15, 31, 15, 31);
            end else if (phase == 1) begin
                set_format(0, 0, 0, 0, 0, 0, 0, 0);
            end else begin
                case ($urandom_range(0, 3))
                    0:       pitch = 0;
                    1:       pitch = 65535;
                    default: pitch = $urandom_range(0, 65535);
                endcase
                // mostly the usual widths, sometimes the wide ones
                for (int c = 0; c < NUM_CHAN; c++) begin
                    sz[c] = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15)
                                                        : $urandom_range(0, 8);
                end
                set_format(pitch, $urandom_range(0, 7),
                           sz[CH_RED],   $urandom_range(0, 31),
                           sz[CH_GREEN], $urandom_range(0, 31),
                           sz[CH_BLUE],  $urandom_range(0, 31));
            end
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                // hold off the sender until the pipe has fully drained
                if (n == PHASE_ITEMS / 2 && phase % 3 == 2) begin
                    wait_for_stores();
                end
                send_pixel(random_pixel());
            end
            wait_for_stores();
        end
    endtask

    // result side: random stall, compare each store with the oldest prediction
    always @(posedge i_clk) begin : store_check
        t_pix_out want;
        if (!i_rst_n) begin
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_stores.size() == 0) begin
                    $display("%0t unexpected store: got %h", $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = expected_stores.pop_front();
                    if (o_out_data.byte_offset !== want.byte_offset) begin
                        $display("%0t byte_offset: expected %h actual %h",
                                 $time, want.byte_offset, o_out_data.byte_offset);
                        mismatch_count++;
                    end
                    if (o_out_data.pixel_word !== want.pixel_word) begin
                        $display("%0t pixel_word: expected %h actual %h",
                                 $time, want.pixel_word, o_out_data.pixel_word);
                        mismatch_count++;
                    end
                    if (o_out_data.store_bytes !== want.store_bytes) begin
                        $display("%0t store_bytes: expected %0d actual %0d",
                                 $time, want.store_bytes, o_out_data.store_bytes);
                        mismatch_count++;
                    end
                end
                stall_left = snk_idle ? $urandom_range(0, MAX_WAIT) : 0;
            end else if (stall_left != 0) begin
                stall_left--;
            end
        end
        i_stall <= (stall_left != 0);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // test sequence
    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in_data <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        fmt_pitch = PITCH_RESET;
        fmt_bpp   = BPP_RESET;
        for (int c = 0; c < NUM_CHAN; c++) begin
            fmt_size[c] = SIZE_RESET;
        end
        fmt_shift[CH_RED]   = RED_SHIFT_RESET;
        fmt_shift[CH_GREEN] = GREEN_SHIFT_RESET;
        fmt_shift[CH_BLUE]  = BLUE_SHIFT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_format();
        test_format_corners();
        test_random_formats();
        wait_for_stores();
        repeat (PIPE_DEPTH) @(posedge i_clk);

        if (mismatch_count == 0 && expected_stores.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
